### hdl/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Types, codes and fixed field widths shared by the text console character
// engine modules.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int POS_FIELD_W  = 14;
	localparam int ADDR_FIELD_W = 14;
	localparam int CELL_W       = 16;

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	typedef struct packed {
		logic                    func;
		logic [7:0]              char_code;
		logic [ADDR_FIELD_W-1:0] read_addr;
	} req_item_t;

	typedef struct packed {
		logic [POS_FIELD_W-1:0] cursor_pos;
		logic [POS_FIELD_W-1:0] screen_start;
		logic [CELL_W-1:0]      read_data;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ_OUT,
		S_EXEC,
		S_CHECK,
		S_FINISH,
		S_COPY_RD,
		S_COPY_WR,
		S_REBASE,
		S_BLANK
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic check;
		logic copy_rd;
		logic copy_wr;
		logic rebase;
		logic blank;
		logic clear;
		logic out_load;
		logic out_read;
	} dp_cmd_t;

	typedef struct packed {
		logic req_read;
		logic scroll;
		logic wrap;
		logic copy_last;
		logic blank_last;
		logic clear_last;
	} dp_stat_t;

endpackage

### hdl/text_console_char_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text console engine: cell store, cursor, view start, scroll and wraparound.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass that fills every cell with
// 0x0F20 and holds req_ready low; attribute writes are taken throughout.
// A read transaction is accepted, then the registered store read is loaded
// as the response; a put is accepted, writes the cell and updates the cursor,
// then does the scroll check. When the cursor runs past the end of the screen
// area, the put instead walks the store: it copies the visible screen to cell
// 0, one cell read and one cell write at a time, rebases, then blanks the
// remaining (SCREEN_COUNT-1)*COLUMNS*LINES cells through the single write port
// of the cell memory. A finished response waits in an output register, and
// the next transaction is accepted while it waits.
module text_console_char_engine #(
	parameter int COLUMNS      = 80,
	parameter int LINES        = 25,
	parameter int SCREEN_COUNT = 8,
	parameter int TAB_STOP     = 8,
	parameter int MEM_CELLS    = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tce_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output tce_pkg::rsp_item_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	tce_pkg::dp_cmd_t  cmd;
	tce_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tce_dp #(
		.COLUMNS     (COLUMNS),
		.LINES       (LINES),
		.SCREEN_COUNT(SCREEN_COUNT),
		.TAB_STOP    (TAB_STOP),
		.MEM_CELLS   (MEM_CELLS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.stat    (stat),
		.rsp     (rsp)
	);

endmodule

### hdl/tce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/tce_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_dp
// Datapath: cell store, cursor and view registers with their residues,
// sweep counters for the wraparound copy, blanking and the clearing pass.
// ----------------------------------------------------------------------------
module tce_dp #(
	parameter int COLUMNS      = 80,
	parameter int LINES        = 25,
	parameter int SCREEN_COUNT = 8,
	parameter int TAB_STOP     = 8,
	parameter int MEM_CELLS    = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tce_pkg::req_item_t  req,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data,
	input  tce_pkg::dp_cmd_t    cmd,
	output tce_pkg::dp_stat_t   stat,
	output tce_pkg::rsp_item_t  rsp
);

	localparam int SCR_CELLS   = COLUMNS * LINES;
	localparam int AREA_END    = SCR_CELLS * SCREEN_COUNT;
	localparam int AW          = $clog2(MEM_CELLS);
	localparam int POS_W       = $clog2(AREA_END + 2 * SCR_CELLS);
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int TAB_W       = $clog2(TAB_STOP);
	localparam int D_W         = $clog2(COLUMNS + 1);
	localparam int MOD_N       = TAB_STOP + COLUMNS;
	localparam int MOD_W       = $clog2(MOD_N);
	localparam int COL_MOD_TAB = COLUMNS % TAB_STOP;
	localparam int SCR_ADDR    = SCR_CELLS % MEM_CELLS;
	localparam int RA_W        = tce_pkg::ADDR_FIELD_W;
	localparam int RD_FOLDS    = ((2 ** RA_W) - 1) / MEM_CELLS + 1;
	localparam int OW          = tce_pkg::POS_FIELD_W;
	localparam int CW          = tce_pkg::CELL_W;

	// residue table for small sums modulo the tab stop
	logic [TAB_W-1:0] tab_mod [MOD_N];
	for (genvar g = 0; g < MOD_N; g++) begin : g_tab_mod
		assign tab_mod[g] = TAB_W'(g % TAB_STOP);
	end

	logic [POS_W-1:0]    cursor_q, view_q, cnt_q;
	logic [COL_W-1:0]    col_q;
	logic [TAB_W-1:0]    tab_q, vtab_q;
	logic [AW-1:0]       caddr_q, vaddr_q, src_q, dst_q;
	logic [7:0]          attr_q;
	tce_pkg::req_item_t  req_q;
	tce_pkg::rsp_item_t  rsp_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [CW-1:0]       ram_wdata, ram_rdata;

	logic [7:0]          code;
	logic                is_bs, bs_ok, is_move;
	logic [D_W-1:0]      step;
	logic [POS_W-1:0]    cursor_fw, cursor_bk;
	logic [COL_W:0]      col_sum;
	logic [COL_W-1:0]    col_fw, col_bk;
	logic [MOD_W-1:0]    tab_idx;
	logic [TAB_W-1:0]    tab_fw, tab_bk;
	logic [AW:0]         caddr_sum;
	logic [AW-1:0]       caddr_fw, caddr_bk;

	logic                scroll, wrap;
	logic [POS_W-1:0]    view_nx;
	logic [AW:0]         vaddr_sum;
	logic [AW-1:0]       vaddr_nx;
	logic [TAB_W:0]      vtab_sum;
	logic [TAB_W-1:0]    vtab_nx;

	logic                keep;
	logic [POS_W-1:0]    cursor_rb;
	logic [AW-1:0]       caddr_rb;
	logic [TAB_W-1:0]    tab_rb;

	logic [AW-1:0]       src_inc, dst_inc;
	logic [RA_W+2:0]     rd_fold;
	logic [AW-1:0]       rd_addr;

	assign code  = req_q.char_code;
	assign is_bs = (code == tce_pkg::CH_BS);
	assign bs_ok = cursor_q > view_q;

	always_comb begin
		is_move = 1'b1;
		case (code)
			tce_pkg::CH_TAB: step = D_W'(TAB_STOP) - D_W'(tab_q);
			tce_pkg::CH_NL:  step = D_W'(COLUMNS) - D_W'(col_q);
			tce_pkg::CH_CR:  step = D_W'(COLUMNS);
			default: begin
				step    = D_W'(1);
				is_move = 1'b0;
			end
		endcase
	end

	// forward move by step, residues wrap at most once
	assign cursor_fw = cursor_q + POS_W'(step);
	assign col_sum   = (COL_W+1)'(col_q) + (COL_W+1)'(step);
	assign col_fw    = (col_sum >= (COL_W+1)'(COLUMNS)) ?
		COL_W'(col_sum - (COL_W+1)'(COLUMNS)) : COL_W'(col_sum);
	assign tab_idx   = MOD_W'(tab_q) + MOD_W'(step);
	assign tab_fw    = tab_mod[tab_idx];
	assign caddr_sum = (AW+1)'(caddr_q) + (AW+1)'(step);
	assign caddr_fw  = (caddr_sum >= (AW+1)'(MEM_CELLS)) ?
		AW'(caddr_sum - (AW+1)'(MEM_CELLS)) : AW'(caddr_sum);

	assign cursor_bk = cursor_q - POS_W'(1);
	assign col_bk    = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
	assign tab_bk    = (tab_q == '0) ? TAB_W'(TAB_STOP - 1) : tab_q - TAB_W'(1);
	assign caddr_bk  = (caddr_q == '0) ? AW'(MEM_CELLS - 1) : caddr_q - AW'(1);

	assign scroll    = (POS_W+1)'(cursor_q) >= ((POS_W+1)'(view_q) + (POS_W+1)'(SCR_CELLS));
	assign wrap      = cursor_q >= POS_W'(AREA_END);
	assign view_nx   = view_q + POS_W'(COLUMNS);
	assign vaddr_sum = (AW+1)'(vaddr_q) + (AW+1)'(COLUMNS);
	assign vaddr_nx  = (vaddr_sum >= (AW+1)'(MEM_CELLS)) ?
		AW'(vaddr_sum - (AW+1)'(MEM_CELLS)) : AW'(vaddr_sum);
	assign vtab_sum  = (TAB_W+1)'(vtab_q) + (TAB_W+1)'(COL_MOD_TAB);
	assign vtab_nx   = (vtab_sum >= (TAB_W+1)'(TAB_STOP)) ?
		TAB_W'(vtab_sum - (TAB_W+1)'(TAB_STOP)) : TAB_W'(vtab_sum);

	// rebase onto cell 0, column unchanged since the view sits on a line start
	assign keep      = cursor_q >= view_q;
	assign cursor_rb = cursor_q - view_q;
	assign caddr_rb  = (caddr_q >= vaddr_q) ? caddr_q - vaddr_q :
		AW'((AW+1)'(caddr_q) + (AW+1)'(MEM_CELLS) - (AW+1)'(vaddr_q));
	assign tab_rb    = (tab_q >= vtab_q) ? tab_q - vtab_q :
		TAB_W'((TAB_W+1)'(tab_q) + (TAB_W+1)'(TAB_STOP) - (TAB_W+1)'(vtab_q));

	assign src_inc = (src_q == AW'(MEM_CELLS - 1)) ? '0 : src_q + AW'(1);
	assign dst_inc = (dst_q == AW'(MEM_CELLS - 1)) ? '0 : dst_q + AW'(1);

	// fold the read address into the store depth
	always_comb begin
		rd_fold = (RA_W+3)'(req.read_addr);
		for (int k = 1; k < RD_FOLDS; k++) begin
			if ((RA_W+3)'(req.read_addr) >= (RA_W+3)'(k * MEM_CELLS)) begin
				rd_fold = (RA_W+3)'(req.read_addr) - (RA_W+3)'(k * MEM_CELLS);
			end
		end
	end
	assign rd_addr = AW'(rd_fold);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = {attr_q, tce_pkg::BLANK_CHAR};
		ram_re    = 1'b0;
		ram_raddr = src_q;
		if (cmd.capture) begin
			ram_re    = 1'b1;
			ram_raddr = rd_addr;
		end
		if (cmd.copy_rd) begin
			ram_re = 1'b1;
		end
		if (cmd.exec) begin
			if (is_bs) begin
				ram_we    = bs_ok;
				ram_waddr = caddr_bk;
			end else if (!is_move) begin
				ram_we    = 1'b1;
				ram_waddr = caddr_q;
				ram_wdata = {attr_q, code};
			end
		end
		if (cmd.copy_wr) begin
			ram_we    = 1'b1;
			ram_wdata = ram_rdata;
		end
		if (cmd.blank) begin
			ram_we = 1'b1;
		end
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_wdata = {tce_pkg::ATTR_RESET, tce_pkg::BLANK_CHAR};
		end
	end

	tce_ram #(
		.WIDTH(CW),
		.DEPTH(MEM_CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			tab_q    <= '0;
			caddr_q  <= '0;
			view_q   <= '0;
			vtab_q   <= '0;
			vaddr_q  <= '0;
			dst_q    <= '0;
			attr_q   <= tce_pkg::ATTR_RESET;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			if (cmd.exec) begin
				if (is_bs) begin
					if (bs_ok) begin
						cursor_q <= cursor_bk;
						col_q    <= col_bk;
						tab_q    <= tab_bk;
						caddr_q  <= caddr_bk;
					end
				end else begin
					cursor_q <= cursor_fw;
					col_q    <= col_fw;
					tab_q    <= tab_fw;
					caddr_q  <= caddr_fw;
				end
			end
			if (cmd.check) begin
				dst_q <= '0;
				if (scroll) begin
					view_q  <= view_nx;
					vaddr_q <= vaddr_nx;
					vtab_q  <= vtab_nx;
				end
			end
			if (cmd.rebase) begin
				if (keep) begin
					cursor_q <= cursor_rb;
					caddr_q  <= caddr_rb;
					tab_q    <= tab_rb;
				end else begin
					cursor_q <= '0;
					caddr_q  <= '0;
					tab_q    <= '0;
					col_q    <= '0;
				end
				view_q  <= '0;
				vaddr_q <= '0;
				vtab_q  <= '0;
				dst_q   <= AW'(SCR_ADDR);
			end
			if (cmd.copy_wr || cmd.blank || cmd.clear) begin
				dst_q <= dst_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.check) begin
			src_q <= vaddr_nx;
			cnt_q <= '0;
		end
		if (cmd.copy_wr) begin
			src_q <= src_inc;
			cnt_q <= cnt_q + POS_W'(1);
		end
		if (cmd.rebase) begin
			cnt_q <= POS_W'(SCR_CELLS);
		end
		if (cmd.blank) begin
			cnt_q <= cnt_q + POS_W'(1);
		end
		if (cmd.out_load) begin
			rsp_q.cursor_pos   <= OW'(cursor_q);
			rsp_q.screen_start <= OW'((cmd.check && scroll) ? view_nx : view_q);
			rsp_q.read_data    <= cmd.out_read ? ram_rdata : '0;
		end
	end

	assign stat.req_read   = (req.func == tce_pkg::FUNC_READ);
	assign stat.scroll     = scroll;
	assign stat.wrap       = wrap;
	assign stat.copy_last  = (cnt_q == POS_W'(SCR_CELLS - 1));
	assign stat.blank_last = (cnt_q == POS_W'(AREA_END - 1));
	assign stat.clear_last = (dst_q == AW'(MEM_CELLS - 1));
	assign rsp = rsp_q;

	a_cursor_not_before_view: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q >= view_q)
		else $error("cursor fell below view start");

	a_cursor_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(AW+1)'(caddr_q) < (AW+1)'(MEM_CELLS))
		else $error("cursor cell address outside store");

	a_rebase_lands_on_first_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rebase |=> (view_q == '0 && cursor_q < POS_W'(SCR_CELLS)))
		else $error("rebase left cursor off the first screen");

endmodule

### hdl/tce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ctrl
// Controller: sequences request handling, scroll check, wraparound copy and
// blanking, the clearing pass after reset and the response register.
// ----------------------------------------------------------------------------
module tce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  tce_pkg::dp_stat_t stat,
	output tce_pkg::dp_cmd_t  cmd
);

	tce_pkg::state_t state_q, state_nx;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tce_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			tce_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_nx = tce_pkg::S_IDLE;
				end
			end
			tce_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nx = stat.req_read ? tce_pkg::S_READ_OUT : tce_pkg::S_EXEC;
				end
			end
			tce_pkg::S_READ_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_read = 1'b1;
					state_nx     = tce_pkg::S_IDLE;
				end
			end
			tce_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = tce_pkg::S_CHECK;
			end
			tce_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.scroll && stat.wrap) begin
					state_nx = tce_pkg::S_COPY_RD;
				end else if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = tce_pkg::S_IDLE;
				end else begin
					state_nx = tce_pkg::S_FINISH;
				end
			end
			tce_pkg::S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = tce_pkg::S_IDLE;
				end
			end
			tce_pkg::S_COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_nx    = tce_pkg::S_COPY_WR;
			end
			tce_pkg::S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_nx    = stat.copy_last ? tce_pkg::S_REBASE : tce_pkg::S_COPY_RD;
			end
			tce_pkg::S_REBASE: begin
				cmd.rebase = 1'b1;
				state_nx   = tce_pkg::S_BLANK;
			end
			tce_pkg::S_BLANK: begin
				cmd.blank = 1'b1;
				if (stat.blank_last) begin
					state_nx = tce_pkg::S_FINISH;
				end
			end
			default: begin
				state_nx = tce_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("response load did not raise valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("pending response overwritten");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=>
			(state_q == tce_pkg::S_EXEC || state_q == tce_pkg::S_READ_OUT))
		else $error("accepted transaction not started");

endmodule
